// ===== design/kvat_pkg.sv =====
package kvat_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int SHOWN_W   = 5;
    localparam int SHOWN_MAX = 31;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // One request on its way down the row of slot cells.
    typedef struct packed {
        logic               active;
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic [VALUE_W-1:0] rvalue;
    } token_t;

endpackage

// ===== design/kvat_cell.sv =====
module kvat_cell
    import kvat_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               active_reg;
    token_t             tok_reg;
    token_t             tok_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        tok_next   = tok_in;
        if (tok_in.active && !tok_in.hit)
        begin
            if (tok_in.op == OP_INSERT)
            begin
                if (!valid_reg)
                begin
                    valid_next   = 1'b1;
                    key_next     = tok_in.key;
                    value_next   = tok_in.value;
                    tok_next.hit = 1'b1;
                end
            end
            else if (valid_reg && (key_reg == tok_in.key))
            begin
                tok_next.hit = 1'b1;
                case (tok_in.op)
                    OP_REMOVE: valid_next = 1'b0;
                    OP_UPDATE: value_next = tok_in.value;
                    OP_SEARCH: tok_next.rvalue = value_reg;
                    default:   tok_next.hit = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= tok_next.active;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        tok_reg   <= tok_next;
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

endmodule

// ===== design/key_value_associative_table.sv =====
// Key/value table of SLOTS entries built as a row of slot cells.
// Request channel: req_valid/req_ready with req_type (insert, remove,
// update, search), req_key and req_value. Response channel:
// resp_valid/resp_ready with resp_status, resp_value and entries_used.
// An accepted request enters the first cell and moves one cell per cycle;
// each cell compares its own slot, and the first free slot (insert) or
// the first valid matching slot (other operations) acts on it.
// The result leaves the last cell and is held in the response register.
// One request is in the row at a time, so a new request is taken only
// after the last one has left the row.
// A request is taken only when the row is empty and the response register
// is free or being read in the same cycle, so a stalled receiver holds the
// response and keeps req_ready low until it is taken.
// Reset clears every valid mark and the occupancy count at once; the
// block takes requests in the first cycle after reset.
module key_value_associative_table
    import kvat_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [OP_W-1:0]            req_type,
    input  logic signed [KEY_W-1:0]    req_key,
    input  logic signed [VALUE_W-1:0]  req_value,
    output logic                       resp_valid,
    input  logic                       resp_ready,
    output logic [STATUS_W-1:0]        resp_status,
    output logic signed [VALUE_W-1:0]  resp_value,
    output logic [SHOWN_W-1:0]         entries_used
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    token_t             links [SLOTS+1];
    token_t             exit_tok;
    logic               busy_reg;
    logic               busy_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               resp_valid_reg;
    logic               resp_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [VALUE_W-1:0] rvalue_reg;
    logic [VALUE_W-1:0] rvalue_next;
    logic [SHOWN_W-1:0] shown_reg;
    logic [SHOWN_W-1:0] shown_next;
    logic [31:0]        count_ext;
    logic               req_take;

    assign req_ready = !busy_reg && (!resp_valid_reg || resp_ready);
    assign req_take  = req_valid && req_ready;

    always_comb
    begin
        links[0].active = req_take;
        links[0].op     = op_t'(req_type);
        links[0].key    = req_key;
        links[0].value  = req_value;
        links[0].hit    = 1'b0;
        links[0].rvalue = '0;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        kvat_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (links[i]),
            .tok_out (links[i+1])
        );
    end

    assign exit_tok = links[SLOTS];

    always_comb
    begin
        busy_next       = busy_reg;
        count_next      = count_reg;
        resp_valid_next = resp_valid_reg;
        status_next     = status_reg;
        rvalue_next     = rvalue_reg;
        if (resp_valid_reg && resp_ready)
        begin
            resp_valid_next = 1'b0;
        end
        if (req_take)
        begin
            busy_next = 1'b1;
        end
        if (exit_tok.active)
        begin
            busy_next       = 1'b0;
            resp_valid_next = 1'b1;
            rvalue_next     = exit_tok.rvalue;
            if (exit_tok.hit)
            begin
                status_next = ST_DONE;
                if (exit_tok.op == OP_INSERT)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (exit_tok.op == OP_REMOVE)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else if (exit_tok.op == OP_INSERT)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_MISS;
            end
        end
        count_ext  = 32'(count_next);
        shown_next = (count_ext > 32'(SHOWN_MAX)) ? SHOWN_W'(SHOWN_MAX)
                                                 : count_ext[SHOWN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rvalue_reg <= rvalue_next;
        shown_reg  <= shown_next;
    end

    assign resp_valid   = resp_valid_reg;
    assign resp_status  = status_reg;
    assign resp_value   = rvalue_reg;
    assign entries_used = shown_reg;

endmodule

// ===== design/kvat_checker.sv =====
module kvat_checker
    import kvat_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                resp_valid,
    input logic                resp_ready,
    input logic [STATUS_W-1:0] resp_status,
    input logic [VALUE_W-1:0]  resp_value,
    input logic [SHOWN_W-1:0]  entries_used
);

    // A stalled response holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp_status)
            && $stable(resp_value) && $stable(entries_used))
        else $error("stalled response changed");

    // Only one request is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while one is in flight");

    // A response never appears in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !resp_valid)
        else $error("response appeared too early");

    // A miss or a dropped insert returns no value.
    assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && (resp_status == ST_MISS || resp_status == ST_FULL)
            |-> resp_value == '0)
        else $error("value returned without a hit");

endmodule

bind key_value_associative_table kvat_checker u_kvat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .resp_valid   (resp_valid),
    .resp_ready   (resp_ready),
    .resp_status  (resp_status),
    .resp_value   (resp_value),
    .entries_used (entries_used)
);
